// File: rtl/s512_pkg.sv
// package for the sha-512 message hash: types, constants, round table
// no dependencies
package s512_pkg;

	localparam int unsigned QueueDepth = 4;

	typedef struct packed {
		logic [63:0] word;
		logic        blk_end;
		logic        msg_end;
	} q_item_t;

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_PAD,
		FE_LEN_HI,
		FE_LEN_LO
	} fe_state_t;

	typedef enum logic [1:0] {
		BE_LOAD,
		BE_ROUND,
		BE_ADD,
		BE_EMIT
	} be_state_t;

	localparam logic [7:0][63:0] InitHash = {
		64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b,
		64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
		64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b,
		64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
	};

	function automatic logic [63:0] round_k(input logic [6:0] t);
		logic [63:0] k;
		case (t)
			7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
			7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
			7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
			7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
			7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
			7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
			7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
			7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
			7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
			7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
			7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
			7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
			7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
			7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
			7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
			7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
			7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
			7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
			7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
			7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
			7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
			7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
			7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
			7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
			7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
			7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
			7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
			7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
			7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
			7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
			7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
			7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
			7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
			7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
			7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
			7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
			7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
			7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
			7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
			7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
			default: k = '0;
		endcase
		return k;
	endfunction

endpackage

// File: rtl/s512_if.sv
// valid/ready channel interfaces for the message and digest streams
// no dependencies
interface s512_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  valid_bytes;
	logic        last_word;
	modport source (output valid, data_word, valid_bytes, last_word, input ready);
	modport sink (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

interface s512_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word;
	logic [2:0]  word_number;
	logic        last_result;
	modport source (output valid, digest_word, word_number, last_result, input ready);
	modport sink (input valid, digest_word, word_number, last_result, output ready);
endinterface

// File: rtl/s512_front.sv
// front end: takes message items, counts bytes, pads and appends the length
// depends on s512_pkg, s512_if
module s512_front (
	input  logic                clk,
	input  logic                arst_n,
	s512_in_if.sink             msg,
	output logic                push,
	output s512_pkg::q_item_t   push_item,
	input  logic                full
);

	s512_pkg::fe_state_t state_q, state_d;
	logic [63:0] bytes_q;
	logic [3:0]  slot_q;
	logic [3:0]  cnt;
	logic [63:0] keep, padded, total;
	logic        take;
	logic        pad_first_q;

	// clamp count, only honored on the last word
	always_comb begin
		cnt = (msg.valid_bytes > 4'd8) ? 4'd8 : msg.valid_bytes;
		if (!msg.last_word) cnt = 4'd8;
		keep = ~(64'hffffffffffffffff >> {cnt[3:0], 3'b000});
		if (cnt == 4'd8) keep = '1;
		padded = (msg.data_word & keep) | (cnt == 4'd8 ? 64'd0 :
			(64'h8000000000000000 >> {cnt[2:0], 3'b000}));
		total = bytes_q + {60'd0, cnt};
	end

	assign take = msg.valid && msg.ready;
	assign msg.ready = (state_q == s512_pkg::FE_IDLE) && !full;

	// next state: a last word always goes through the fill state, which
	// stops at slot 14 once any pending pad byte is out
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			s512_pkg::FE_IDLE:
				if (take && msg.last_word) state_d = s512_pkg::FE_PAD;
			s512_pkg::FE_PAD:
				if (!full && slot_q == 4'd14 && !pad_first_q)
					state_d = s512_pkg::FE_LEN_HI;
			s512_pkg::FE_LEN_HI:
				if (!full) state_d = s512_pkg::FE_LEN_LO;
			s512_pkg::FE_LEN_LO:
				if (!full) state_d = s512_pkg::FE_IDLE;
			default: state_d = s512_pkg::FE_IDLE;
		endcase
	end

	// queue push: pad words after a short last word are zero,
	// after a full last word the first one carries the pad byte
	always_comb begin
		push = 1'b0;
		push_item.word = '0;
		push_item.blk_end = (slot_q == 4'd15);
		push_item.msg_end = 1'b0;
		unique case (state_q)
			s512_pkg::FE_IDLE: begin
				push = take;
				push_item.word = msg.last_word ? padded : msg.data_word;
			end
			s512_pkg::FE_PAD: begin
				push = !full && (slot_q != 4'd14 || pad_first_q);
				push_item.word = pad_first_q ? 64'h8000000000000000 : 64'd0;
			end
			s512_pkg::FE_LEN_HI: push = !full;
			s512_pkg::FE_LEN_LO: begin
				push = !full;
				push_item.word = {bytes_q[60:0], 3'b000};
				push_item.msg_end = 1'b1;
			end
			default: push = 1'b0;
		endcase
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= s512_pkg::FE_IDLE;
			bytes_q     <= '0;
			slot_q      <= '0;
			pad_first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == s512_pkg::FE_LEN_LO && !full) begin
				bytes_q <= '0;
				slot_q  <= '0;
			end else begin
				if (push) slot_q <= slot_q + 4'd1;
				if (take) bytes_q <= total;
			end
			if (take) pad_first_q <= msg.last_word && cnt == 4'd8;
			else if (push) pad_first_q <= 1'b0;
		end
	end

endmodule

// File: rtl/s512_queue.sv
// short fifo between the padding front end and the compression back end
// depends on s512_pkg
module s512_queue #(
	parameter int unsigned Depth = s512_pkg::QueueDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  s512_pkg::q_item_t push_item,
	output logic              full,
	input  logic              pop,
	output s512_pkg::q_item_t head,
	output logic              empty
);

	localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

	s512_pkg::q_item_t mem_q [Depth];
	logic [Aw-1:0] wr_q, rd_q;
	logic [Aw:0]   cnt_q;

	assign full  = (cnt_q == Aw'(0) + (Aw+1)'(Depth));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= push_item;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full)
				wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + Aw'(1);
			if (pop && !empty)
				rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + Aw'(1);
			cnt_q <= cnt_q + (Aw+1)'(push && !full) - (Aw+1)'(pop && !empty);
		end
	end

endmodule

// File: rtl/s512_core.sv
// back end: schedule window, 80-round compression, digest emission
// depends on s512_pkg, s512_if
module s512_core (
	input  logic              clk,
	input  logic              arst_n,
	input  s512_pkg::q_item_t head,
	input  logic              empty,
	output logic              pop,
	s512_out_if.source        dig
);

	s512_pkg::be_state_t state_q, state_d;
	logic [63:0] w_q [16];
	logic [7:0][63:0] h_q, r_q;
	logic [6:0]  rnd_q;
	logic [3:0]  slot_q;
	logic [2:0]  idx_q;
	logic        fin_q;

	logic [63:0] a2, a15, s0, s1, wt, wnew, big0, big1, ch, maj, t1, t2;
	logic        last_round;

	function automatic logic [63:0] ror(input logic [63:0] x, input int unsigned n);
		return (x >> n) | (x << (64 - n));
	endfunction

	// round datapath
	always_comb begin
		a2   = w_q[4'(rnd_q - 7'd2)];
		a15  = w_q[4'(rnd_q - 7'd15)];
		s1   = ror(a2, 19) ^ ror(a2, 61) ^ (a2 >> 6);
		s0   = ror(a15, 1) ^ ror(a15, 8) ^ (a15 >> 7);
		wnew = s1 + w_q[4'(rnd_q - 7'd7)] + s0 + w_q[rnd_q[3:0]];
		wt   = (rnd_q >= 7'd16) ? wnew : w_q[rnd_q[3:0]];
		big1 = ror(r_q[4], 14) ^ ror(r_q[4], 18) ^ ror(r_q[4], 41);
		ch   = (r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]);
		big0 = ror(r_q[0], 28) ^ ror(r_q[0], 34) ^ ror(r_q[0], 39);
		maj  = (r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]);
		t1   = r_q[7] + big1 + ch + s512_pkg::round_k(rnd_q) + wt;
		t2   = big0 + maj;
		last_round = (rnd_q == 7'd79);
	end

	assign pop = (state_q == s512_pkg::BE_LOAD) && !empty;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			s512_pkg::BE_LOAD:  if (pop && head.blk_end) state_d = s512_pkg::BE_ROUND;
			s512_pkg::BE_ROUND: if (last_round) state_d = s512_pkg::BE_ADD;
			s512_pkg::BE_ADD:   state_d = fin_q ? s512_pkg::BE_EMIT : s512_pkg::BE_LOAD;
			s512_pkg::BE_EMIT:  if (dig.ready && idx_q == 3'd7) state_d = s512_pkg::BE_LOAD;
			default:            state_d = s512_pkg::BE_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		dig.valid       = (state_q == s512_pkg::BE_EMIT);
		dig.digest_word = h_q[idx_q];
		dig.word_number = idx_q;
		dig.last_result = (idx_q == 3'd7);
	end

	// schedule window storage
	always_ff @(posedge clk) begin
		if (pop) w_q[slot_q] <= head.word;
		else if (state_q == s512_pkg::BE_ROUND && rnd_q >= 7'd16) w_q[rnd_q[3:0]] <= wnew;
	end

	// working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= s512_pkg::BE_LOAD;
			h_q     <= s512_pkg::InitHash;
			r_q     <= '0;
			rnd_q   <= '0;
			slot_q  <= '0;
			idx_q   <= '0;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				s512_pkg::BE_LOAD: if (pop) begin
					slot_q <= slot_q + 4'd1;
					if (head.blk_end) begin
						r_q   <= h_q;
						fin_q <= head.msg_end;
						rnd_q <= '0;
					end
				end
				s512_pkg::BE_ROUND: begin
					r_q   <= {r_q[6:4], r_q[3] + t1, r_q[2:0], t1 + t2};
					rnd_q <= last_round ? 7'd0 : rnd_q + 7'd1;
				end
				s512_pkg::BE_ADD:
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + r_q[i];
				s512_pkg::BE_EMIT: if (dig.ready) begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd7) h_q <= s512_pkg::InitHash;
				end
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/sha512_message_hash.sv
// SHA-512 over a stream of 64-bit big-endian message words. The front end pads
// and appends the length into a short queue, the back end compresses each
// 16-word block with one load per word, 80 rounds at one a cycle and a final
// chain add. A last item finishes its block with the pad byte and the length,
// which can take one more block, then eight digest items follow.
// depends on s512_pkg, s512_if, s512_front, s512_queue, s512_core
module sha512_message_hash #(
	parameter int unsigned QueueDepth = s512_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	s512_in_if.sink     msg,
	s512_out_if.source  dig
);

	logic              push, full, pop, empty;
	s512_pkg::q_item_t push_item, head;

	s512_front u_front (
		.clk, .arst_n, .msg, .push, .push_item, .full
	);

	s512_queue #(.Depth(QueueDepth)) u_queue (
		.clk, .arst_n, .push, .push_item, .full, .pop, .head, .empty
	);

	s512_core u_core (
		.clk, .arst_n, .head, .empty, .pop, .dig
	);

endmodule
